/* rtl/core/sl3x_pkg.sv */
// Shared widths, constants and control types for the ln(3+x) series evaluator.
`default_nettype none

package sl3x_pkg;

    localparam int IO_W       = 32;
    localparam int ACC_W      = 40;
    localparam int MAG_W      = 39;
    localparam int RMAG_W     = 30;
    localparam int CNT_W      = 8;
    localparam int ADDR_W     = 3;
    localparam int DIV_W      = 40;
    localparam int DIV_RADIX  = 8;
    localparam int DIV_STEPS  = DIV_W / DIV_RADIX;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [31:0] RECIP3   = 32'hAAAA_AAAB;
    localparam logic [63:0] LN3_Q32  = 64'd4718503851;

    localparam logic [CNT_W-1:0] TERM_COUNT_RESET = 8'd100;
    localparam logic             REG_TERM_COUNT   = 1'b0;

    typedef struct packed {
        logic load;
        logic recip;
        logic mul_lo;
        logic mul_hi;
        logic combine;
        logic div_step;
        logic accum;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic zero_terms;
        logic last_term;
    } status_t;

endpackage

`default_nettype wire

/* rtl/core/sl3x_regs.sv */
// APB-style configuration register holding the term count.
`default_nettype none

module sl3x_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sl3x_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output logic      [sl3x_pkg::CNT_W-1:0]  term_count
);
    import sl3x_pkg::*;

    logic [CNT_W-1:0] term_count_reg;
    logic             wr_en;
    logic             reg_index;

    assign reg_index = paddr[2];
    assign wr_en     = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= TERM_COUNT_RESET;
        end
        else if (wr_en && (reg_index == REG_TERM_COUNT))
        begin
            term_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        if (reg_index == REG_TERM_COUNT)
        begin
            prdata = {{(32-CNT_W){1'b0}}, term_count_reg};
        end
        else
        begin
            prdata = 32'd0;
        end
    end

    assign term_count = term_count_reg;

endmodule

`default_nettype wire

/* rtl/core/sl3x_ctrl.sv */
// Sequencing state machine for the series evaluation.
`default_nettype none

module sl3x_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire sl3x_pkg::status_t status,
    output sl3x_pkg::cmd_t         cmd,
    output logic                   busy,
    output logic                   done
);
    import sl3x_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RECIP   = 3'd1;
    localparam logic [2:0] S_MUL_LO  = 3'd2;
    localparam logic [2:0] S_MUL_HI  = 3'd3;
    localparam logic [2:0] S_COMBINE = 3'd4;
    localparam logic [2:0] S_DIV     = 3'd5;
    localparam logic [2:0] S_ACCUM   = 3'd6;
    localparam logic [2:0] S_FINISH  = 3'd7;

    localparam logic [DIV_CNT_W-1:0] DivLast = DIV_CNT_W'(DIV_STEPS - 1);

    logic [2:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 done_reg, done_next;

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        done_next    = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RECIP;
                end
            end
            S_RECIP:
            begin
                cmd.recip  = 1'b1;
                state_next = status.zero_terms ? S_FINISH : S_MUL_LO;
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_COMBINE;
            end
            S_COMBINE:
            begin
                cmd.combine  = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = DIV_CNT_W'(div_cnt_reg + 1'b1);
                if (div_cnt_reg == DivLast)
                begin
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = status.last_term ? S_FINISH : S_MUL_LO;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            done_reg    <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    // The result strobe falls back on the next cycle, since a new request passes through S_RECIP and S_FINISH first.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result strobe while still evaluating");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done_reg))
        else $error("accepted request did not start an evaluation");

    a_div_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMBINE) |=> (state_reg == S_DIV && div_cnt_reg == '0))
        else $error("division did not start from its first step");

endmodule

`default_nettype wire

/* rtl/core/sl3x_dpath.sv */
// Datapath: shared multiplier, rounding, radix-256 divider and saturating accumulator.
`default_nettype none

module sl3x_dpath #(
    parameter int MAX_TERMS = 128,
    parameter int FRAC_BITS = 27
) (
    input  wire logic                       clk,
    input  wire sl3x_pkg::cmd_t             cmd,
    output sl3x_pkg::status_t               status,
    input  wire logic [sl3x_pkg::IO_W-1:0]  x_value,
    input  wire logic [sl3x_pkg::CNT_W-1:0] term_count,
    output logic      [sl3x_pkg::IO_W-1:0]  series_value,
    output logic                            overflowed
);
    import sl3x_pkg::*;

    localparam int PROD_W = MAG_W + RMAG_W + 2;

    localparam logic [CNT_W-1:0]  MaxTermsC = CNT_W'(MAX_TERMS);
    localparam logic [ACC_W-1:0]  Ln3Init   =
        ACC_W'((LN3_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
    localparam logic [MAG_W-1:0]  PowerOne  = MAG_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0] RoundHalf = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [MAG_W-1:0]  MagMax    = {MAG_W{1'b1}};
    localparam logic [ACC_W-1:0]  AccMax    = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0]  AccMin    = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [IO_W-1:0]   OutMax    = {1'b0, {(IO_W-1){1'b1}}};
    localparam logic [IO_W-1:0]   OutMin    = {1'b1, {(IO_W-1){1'b0}}};

    // Argument and ratio r = x/3 in sign-magnitude form.
    logic [IO_W-1:0]    xabs_reg;
    logic               xneg_reg;
    logic [RMAG_W-1:0]  rmag_reg;
    logic               rneg_reg;

    // Running power in sign-magnitude form and the running sum.
    logic [MAG_W-1:0]   pmag_reg;
    logic               psign_reg;
    logic [ACC_W-1:0]   sum_reg;
    logic               ovf_reg;
    logic [CNT_W-1:0]   k_reg;

    logic [61:0]        prod_lo_reg;
    logic [36:0]        prod_hi_reg;

    logic [DIV_W-1:0]     div_num_reg;
    logic [DIV_W-1:0]     div_quo_reg;
    logic [CNT_W-1:0]     div_rem_reg;

    logic [IO_W-1:0]    series_value_reg;
    logic               overflowed_reg;

    logic [CNT_W-1:0]   n_terms;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;
    logic [PROD_W-1:0]  full_sum;
    logic [PROD_W-1:0]  rounded;
    logic               pow_sat;
    logic [MAG_W-1:0]   pmag_new;
    logic [CNT_W-1:0]   div_rem_new;
    logic [DIV_RADIX-1:0] div_qbits;
    logic               tneg;
    logic [ACC_W-1:0]   term;
    logic [ACC_W:0]     sum_wide;
    logic               sum_sat;
    logic [ACC_W-1:0]   sum_new;
    logic               out_sat;
    logic [IO_W-1:0]    out_new;

    assign n_terms = (term_count > MaxTermsC) ? MaxTermsC : term_count;
    assign status.zero_terms = (n_terms == '0);
    assign status.last_term  = (k_reg == n_terms);

    // One 32x32 multiplier serves the division by three and both partial products.
    always_comb
    begin
        priority if (cmd.recip)
        begin
            mul_a = xabs_reg;
            mul_b = RECIP3;
        end
        else if (cmd.mul_hi)
        begin
            mul_a = {{(32-(MAG_W-32)){1'b0}}, pmag_reg[MAG_W-1:32]};
            mul_b = {{(32-RMAG_W){1'b0}}, rmag_reg};
        end
        else
        begin
            mul_a = pmag_reg[31:0];
            mul_b = {{(32-RMAG_W){1'b0}}, rmag_reg};
        end
    end

    assign mul_p = mul_a * mul_b;

    // Power update: round to nearest, drop the fraction bits and clamp the magnitude.
    assign full_sum = PROD_W'(prod_lo_reg) + (PROD_W'(prod_hi_reg) << 32) + RoundHalf;
    assign rounded  = full_sum >> FRAC_BITS;
    assign pow_sat  = |rounded[PROD_W-1:MAG_W];
    assign pmag_new = pow_sat ? MagMax : rounded[MAG_W-1:0];

    // Eight restoring steps per cycle on the top byte of the dividend.
    always_comb
    begin
        logic [CNT_W:0]   trial;
        logic [CNT_W-1:0] rem;
        rem       = div_rem_reg;
        div_qbits = '0;
        for (int i = DIV_RADIX - 1; i >= 0; i--)
        begin
            trial = {rem, div_num_reg[DIV_W-DIV_RADIX+i]};
            if (trial >= {1'b0, k_reg})
            begin
                rem          = CNT_W'(trial - {1'b0, k_reg});
                div_qbits[i] = 1'b1;
            end
            else
            begin
                rem = trial[CNT_W-1:0];
            end
        end
        div_rem_new = rem;
    end

    // Even terms are subtracted, so the term sign flips against the power sign.
    assign tneg     = psign_reg ^ ~k_reg[0];
    assign term     = tneg ? ACC_W'(~div_quo_reg + 1'b1) : div_quo_reg;
    assign sum_wide = {sum_reg[ACC_W-1], sum_reg} + {term[ACC_W-1], term};
    assign sum_sat  = (sum_wide[ACC_W] != sum_wide[ACC_W-1]);
    assign sum_new  = sum_sat ? (sum_wide[ACC_W] ? AccMin : AccMax) : sum_wide[ACC_W-1:0];

    assign out_sat = !((&sum_reg[ACC_W-1:IO_W-1]) || !(|sum_reg[ACC_W-1:IO_W-1]));
    assign out_new = out_sat ? (sum_reg[ACC_W-1] ? OutMin : OutMax) : sum_reg[IO_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            xabs_reg  <= x_value[IO_W-1] ? IO_W'(~x_value + 1'b1) : x_value;
            xneg_reg  <= x_value[IO_W-1];
            sum_reg   <= Ln3Init;
            pmag_reg  <= PowerOne;
            psign_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            k_reg     <= CNT_W'(1);
        end
        if (cmd.recip)
        begin
            rmag_reg <= mul_p[62:33];
            rneg_reg <= xneg_reg;
        end
        if (cmd.mul_lo)
        begin
            prod_lo_reg <= mul_p[61:0];
        end
        if (cmd.mul_hi)
        begin
            prod_hi_reg <= mul_p[36:0];
        end
        if (cmd.combine)
        begin
            pmag_reg    <= pmag_new;
            psign_reg   <= (psign_reg ^ rneg_reg) && (pmag_new != '0);
            ovf_reg     <= ovf_reg | pow_sat;
            div_num_reg <= DIV_W'(pmag_new);
            div_quo_reg <= '0;
            div_rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            div_num_reg <= div_num_reg << DIV_RADIX;
            div_quo_reg <= {div_quo_reg[DIV_W-DIV_RADIX-1:0], div_qbits};
            div_rem_reg <= div_rem_new;
        end
        if (cmd.accum)
        begin
            sum_reg <= sum_new;
            ovf_reg <= ovf_reg | sum_sat;
            k_reg   <= CNT_W'(k_reg + 1'b1);
        end
        if (cmd.finish)
        begin
            series_value_reg <= out_new;
            overflowed_reg   <= ovf_reg | out_sat;
        end
    end

    assign series_value = series_value_reg;
    assign overflowed   = overflowed_reg;

endmodule

`default_nettype wire

/* rtl/core/series_log_three_plus_x.sv */
// Top level of the ln(3+x) truncated series evaluator.
//
//  channel   ports                                  direction  transfer
//  request   start, busy, x_value                   in         start && !busy
//  result    done, series_value, overflowed         out        done, one cycle
//  config    psel, penable, pwrite, paddr, pwdata,  in/out     psel && penable && pwrite
//            prdata, pready
//
// A request evaluates n terms between acceptance and the result strobe, where n is
// term_count limited to MAX_TERMS; each term is two partial products on the shared
// 32x32 multiplier, a rounding step, five radix-256 division steps and an accumulate.
// The reset term count is 100.
// Reset is asynchronous and needs no clearing pass; busy is low straight after it.
// A new request can be accepted in the cycle in which the result strobe is shown.
// The receiver cannot hold results off, so the block never stalls on its output.
`default_nettype none

module series_log_three_plus_x #(
    parameter int MAX_TERMS = 128,
    parameter int FRAC_BITS = 27
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [sl3x_pkg::IO_W-1:0]   x_value,
    output logic                             done,
    output logic      [sl3x_pkg::IO_W-1:0]   series_value,
    output logic                             overflowed,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sl3x_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);
    import sl3x_pkg::*;

    cmd_t             cmd;
    status_t          status;
    logic [CNT_W-1:0] term_count;

    sl3x_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .term_count (term_count)
    );

    sl3x_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    sl3x_dpath #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk          (clk),
        .cmd          (cmd),
        .status       (status),
        .x_value      (x_value),
        .term_count   (term_count),
        .series_value (series_value),
        .overflowed   (overflowed)
    );

endmodule

`default_nettype wire
